// ===== sv/csvt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// csvt_pkg
// Token codes, control characters and register indexes for the CSV field
// tokenizer.
// ----------------------------------------------------------------------------
package csvt_pkg;

	typedef enum logic [1:0] {
		TK_CHAR  = 2'd0,
		TK_FIELD = 2'd1,
		TK_ROW   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		REG_SEPARATOR = 2'd0,
		REG_QUOTE     = 2'd1,
		REG_ESCAPE    = 2'd2
	} reg_idx_t;

	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_LF = 8'd10;

	localparam logic [7:0] SEPARATOR_RESET = 8'd44;
	localparam logic [7:0] QUOTE_RESET     = 8'd34;
	localparam logic [7:0] ESCAPE_RESET    = 8'd92;

	localparam int unsigned MAX_TOKENS = 3;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
	} tok_t;

	// tokens caused by one byte, filled from entry zero
	typedef struct packed {
		logic [1:0]                 cnt;
		tok_t [MAX_TOKENS-1:0]      tok;
	} grp_t;

endpackage
`default_nettype wire

// ===== sv/csv_field_tokenizer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// csv_field_tokenizer_unit
// Splits a byte stream into field characters, field ends and row ends, with
// quoted fields and an escape character; separator, quote and escape are
// set through a write port.
// ----------------------------------------------------------------------------
// path: an accepted byte's tokens are written to the token buffer, then move
//   one at a time into the output register; out_ready can stall them there
// throughput: one byte per cycle while each byte gives at most one token and
//   the output is not stalled; a byte that gives more tokens holds the token buffer until its last is popped
// reset: plain mode, nothing pending, at field start, registers 44/34/92
module csv_field_tokenizer_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,

	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,

	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] byte_in,
	input  wire logic       end_of_data,

	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      token_kind,
	output logic [7:0]      char_out,
	output logic            last_of_step
);

	logic [7:0] sep_q;
	logic [7:0] quo_q;
	logic [7:0] esc_q;

	logic       in_quotes_q;
	logic       pend_valid_q;
	logic [7:0] pend_byte_q;
	logic       field_start_q;

	logic [1:0]                                grp_cnt_s1;
	csvt_pkg::tok_t [csvt_pkg::MAX_TOKENS-1:0] grp_tok_s1;
	csvt_pkg::tok_t out_tok_q;
	logic           out_valid_q;
	logic           out_last_q;

	logic           in_acc;
	logic           grp_pop;

	logic           iq_n;
	logic           pv_n;
	logic [7:0]     pb_n;
	logic           fs_n;
	logic           row_end;
	logic           do_plain;
	csvt_pkg::grp_t grp_n;

	function automatic csvt_pkg::grp_t push(input csvt_pkg::grp_t g,
		input csvt_pkg::kind_t k, input logic [7:0] ch);
		csvt_pkg::grp_t r;
		r = g;
		if (g.cnt != 2'd3) begin
			r.tok[g.cnt].kind = k;
			r.tok[g.cnt].ch   = (k == csvt_pkg::TK_CHAR) ? ch : 8'd0;
			r.cnt             = g.cnt + 2'd1;
		end
		return r;
	endfunction

	assign grp_pop  = (grp_cnt_s1 != 2'd0) && (!out_valid_q || out_ready);
	assign in_ready = (grp_cnt_s1 == 2'd0) || ((grp_cnt_s1 == 2'd1) && grp_pop);
	assign in_acc   = in_valid && in_ready;

	// next state and tokens for the byte at the input
	always_comb begin
		iq_n     = in_quotes_q;
		pv_n     = pend_valid_q;
		pb_n     = pend_byte_q;
		fs_n     = field_start_q;
		row_end  = 1'b0;
		do_plain = 1'b0;
		grp_n    = '0;

		if (in_quotes_q) begin
			if (pend_valid_q && pend_byte_q == esc_q) begin
				if (!(byte_in == esc_q || byte_in == quo_q || byte_in == sep_q))
					grp_n = push(grp_n, csvt_pkg::TK_CHAR, pend_byte_q);
				pv_n  = 1'b0;
				pb_n  = 8'd0;
				grp_n = push(grp_n, csvt_pkg::TK_CHAR, byte_in);
			end else if (pend_valid_q && pend_byte_q == quo_q) begin
				if (byte_in == sep_q) begin
					grp_n = push(grp_n, csvt_pkg::TK_FIELD, 8'd0);
					iq_n  = 1'b0;
					pv_n  = 1'b0;
					pb_n  = 8'd0;
					fs_n  = 1'b1;
				end else if (byte_in == csvt_pkg::CH_CR || byte_in == csvt_pkg::CH_LF) begin
					// closing quote, then the line break is handled as plain
					pv_n     = 1'b0;
					pb_n     = 8'd0;
					iq_n     = 1'b0;
					do_plain = 1'b1;
				end else begin
					if (byte_in != quo_q)
						grp_n = push(grp_n, csvt_pkg::TK_CHAR, pend_byte_q);
					pv_n  = 1'b0;
					pb_n  = 8'd0;
					grp_n = push(grp_n, csvt_pkg::TK_CHAR, byte_in);
				end
			end else begin
				// stale pending byte after a register change goes out literally
				if (pend_valid_q) begin
					grp_n = push(grp_n, csvt_pkg::TK_CHAR, pend_byte_q);
					pv_n  = 1'b0;
					pb_n  = 8'd0;
				end
				if (byte_in == quo_q || byte_in == esc_q) begin
					pv_n = 1'b1;
					pb_n = byte_in;
				end else begin
					grp_n = push(grp_n, csvt_pkg::TK_CHAR, byte_in);
				end
			end
		end else begin
			do_plain = 1'b1;
		end

		if (do_plain) begin
			if (pv_n) begin
				if (pb_n != csvt_pkg::CH_CR && byte_in != csvt_pkg::CH_LF)
					grp_n = push(grp_n, csvt_pkg::TK_CHAR, pb_n);
				pv_n = 1'b0;
				pb_n = 8'd0;
				fs_n = 1'b0;
			end
			if (byte_in == csvt_pkg::CH_CR) begin
				pv_n = 1'b1;
				pb_n = byte_in;
			end else if (byte_in == csvt_pkg::CH_LF) begin
				grp_n   = push(grp_n, csvt_pkg::TK_ROW, 8'd0);
				row_end = 1'b1;
				iq_n    = 1'b0;
				pv_n    = 1'b0;
				pb_n    = 8'd0;
				fs_n    = 1'b1;
			end else if (byte_in == sep_q) begin
				grp_n = push(grp_n, csvt_pkg::TK_FIELD, 8'd0);
				iq_n  = 1'b0;
				pv_n  = 1'b0;
				pb_n  = 8'd0;
				fs_n  = 1'b1;
			end else if (byte_in == quo_q && fs_n) begin
				iq_n = 1'b1;
				fs_n = 1'b0;
			end else begin
				grp_n = push(grp_n, csvt_pkg::TK_CHAR, byte_in);
				fs_n  = 1'b0;
			end
		end

		if (end_of_data && !row_end) begin
			grp_n = push(grp_n, csvt_pkg::TK_ROW, 8'd0);
			iq_n  = 1'b0;
			pv_n  = 1'b0;
			pb_n  = 8'd0;
			fs_n  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q <= csvt_pkg::SEPARATOR_RESET;
			quo_q <= csvt_pkg::QUOTE_RESET;
			esc_q <= csvt_pkg::ESCAPE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				csvt_pkg::REG_SEPARATOR: sep_q <= cfg_data;
				csvt_pkg::REG_QUOTE:     quo_q <= cfg_data;
				csvt_pkg::REG_ESCAPE:    esc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_quotes_q   <= 1'b0;
			pend_valid_q  <= 1'b0;
			pend_byte_q   <= 8'd0;
			field_start_q <= 1'b1;
		end else if (in_acc) begin
			in_quotes_q   <= iq_n;
			pend_valid_q  <= pv_n;
			pend_byte_q   <= pb_n;
			field_start_q <= fs_n;
		end
	end

	// token buffer: new group on accept, else shift down on pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_cnt_s1 <= 2'd0;
		end else if (in_acc) begin
			grp_cnt_s1 <= grp_n.cnt;
		end else if (grp_pop) begin
			grp_cnt_s1 <= grp_cnt_s1 - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			grp_tok_s1 <= grp_n.tok;
		end else if (grp_pop) begin
			grp_tok_s1[0] <= grp_tok_s1[1];
			grp_tok_s1[1] <= grp_tok_s1[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (grp_pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (grp_pop) begin
			out_tok_q  <= grp_tok_s1[0];
			out_last_q <= (grp_cnt_s1 == 2'd1);
		end
	end

	assign out_valid    = out_valid_q;
	assign token_kind   = out_tok_q.kind;
	assign char_out     = out_tok_q.ch;
	assign last_of_step = out_last_q;

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (token_kind != 2'd3))
		else $error("token kind out of range");

	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && token_kind != csvt_pkg::TK_CHAR) |-> (char_out == 8'd0))
		else $error("nonzero character on a field or row end");

	a_eod_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && end_of_data) |=> (field_start_q && !in_quotes_q && !pend_valid_q))
		else $error("state not back at field start after end of data");

	a_pop_fills: assert property (@(posedge clk) disable iff (!arst_n)
		grp_pop |=> out_valid_q)
		else $error("token lost between buffer and output register");

endmodule
`default_nettype wire
